### rtl/core/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and codes of the bounded array list engine: request codes,
// datapath commands and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 11;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
  localparam logic [OP_W-1:0] OP_DEDUP  = 3'd6;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_NOP      = 4'd0;
  localparam cmd_t CMD_LOAD     = 4'd1;
  localparam cmd_t CMD_ZERO     = 4'd2;
  localparam cmd_t CMD_APPEND   = 4'd3;
  localparam cmd_t CMD_FAIL     = 4'd4;
  localparam cmd_t CMD_INS      = 4'd5;
  localparam cmd_t CMD_DEL      = 4'd6;
  localparam cmd_t CMD_RD_ISSUE = 4'd7;
  localparam cmd_t CMD_RD_DONE  = 4'd8;
  localparam cmd_t CMD_SRCH     = 4'd9;
  localparam cmd_t CMD_CLEAR    = 4'd10;
  localparam cmd_t CMD_DD_RDI   = 4'd11;
  localparam cmd_t CMD_DD_CUR   = 4'd12;
  localparam cmd_t CMD_DD_SCAN  = 4'd13;
  localparam cmd_t CMD_DD_END   = 4'd14;
  localparam cmd_t CMD_PUSH     = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            pos_le_cnt;
    logic            pos_lt_cnt;
    logic            pos_lt_cap;
    logic            i_lt_cnt;
    logic            ins_fin;
    logic            del_fin;
    logic            srch_fin;
    logic            dd_fin;
    logic            zero_last;
  } stat_t;

endpackage

### rtl/core/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of signed 32-bit values in a fixed store with a fill count.
// ----------------------------------------------------------------------------
// After reset the engine zeroes its store, one entry per cycle, with
// s_axis_tready low. It then takes one request at a time. The store has
// one write and one read port with a registered read, so every walk moves
// one entry per cycle: insert moves the entries from the position up by
// one, delete moves those after it down by one, search scans from the
// position until a hit or the end, and remove duplicates compares each
// entry with every later one. A finished result sits in the output
// register while the next request is taken.
module bounded_array_list_engine import bale_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // op[2:0], position[13:3], value[45:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // ok[0], data[32:1], length[43:33]
);

  cmd_t                    cmd;
  stat_t                   st;
  logic                    out_ok;
  logic signed [VAL_W-1:0] out_data;
  logic [LEN_W-1:0]        out_length;

  bale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bale_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_op       (s_axis_tdata[2:0]),
    .in_position (s_axis_tdata[13:3]),
    .in_value    (s_axis_tdata[45:14]),
    .st          (st),
    .out_ok      (out_ok),
    .out_data    (out_data),
    .out_length  (out_length)
  );

  assign m_axis_tdata = {4'b0, out_length, out_data, out_ok};

endmodule

### rtl/core/bale_datapath.sv
// ----------------------------------------------------------------------------
// bale_datapath
// Entry store, fill count, walk indices, compare and result registers.
// Executes one command from the controller each cycle.
// ----------------------------------------------------------------------------
module bale_datapath import bale_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic [OP_W-1:0]         in_op,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output stat_t                   st,
  output logic                    out_ok,
  output logic signed [VAL_W-1:0] out_data,
  output logic [LEN_W-1:0]        out_length
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;

  logic [CW-1:0]    cnt, cnt_next;
  logic [CW-1:0]    i, i_next;
  logic [CW-1:0]    j, j_next;
  logic [CW-1:0]    kept, kept_next;
  logic [CW-1:0]    pa, pa_next;
  logic             pv, pv_next;
  logic [OP_W-1:0]  op_r, op_r_next;
  logic [POS_W-1:0] pos_r, pos_r_next;
  logic [VAL_W-1:0] val_r, val_r_next;
  logic [VAL_W-1:0] cur, cur_next;
  logic             res_ok, res_ok_next;
  logic [VAL_W-1:0] res_data, res_data_next;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata;

  logic i_gt_pos, i1_lt_cnt, i_lt_cnt, j_lt_cnt, hit_val, hit_cur;

  assign i_gt_pos  = 32'(i) > 32'(pos_r);
  assign i1_lt_cnt = (i + CW'(1)) < cnt;
  assign i_lt_cnt  = i < cnt;
  assign j_lt_cnt  = j < cnt;
  assign hit_val   = pv && (rdata == val_r);
  assign hit_cur   = pv && (rdata == cur);

  always_comb begin
    st.op         = op_r;
    st.full       = cnt == CW'(CAPACITY);
    st.pos_le_cnt = 32'(pos_r) <= 32'(cnt);
    st.pos_lt_cnt = 32'(pos_r) < 32'(cnt);
    st.pos_lt_cap = 32'(pos_r) < 32'(CAPACITY);
    st.i_lt_cnt   = i_lt_cnt;
    st.ins_fin    = !i_gt_pos && !pv;
    st.del_fin    = !i1_lt_cnt && !pv;
    st.srch_fin   = hit_val || (!pv && !i_lt_cnt);
    st.dd_fin     = hit_cur || (!pv && !j_lt_cnt);
    st.zero_last  = i == CW'(CAPACITY - 1);
  end

  always_comb begin
    we            = 1'b0;
    re            = 1'b0;
    waddr         = '0;
    raddr         = '0;
    wdata         = '0;
    cnt_next      = cnt;
    i_next        = i;
    j_next        = j;
    kept_next     = kept;
    pa_next       = pa;
    pv_next       = 1'b0;
    op_r_next     = op_r;
    pos_r_next    = pos_r;
    val_r_next    = val_r;
    cur_next      = cur;
    res_ok_next   = res_ok;
    res_data_next = res_data;
    case (cmd)
      CMD_LOAD: begin
        op_r_next  = in_op;
        pos_r_next = in_position;
        val_r_next = in_value;
        kept_next  = '0;
        if (in_op == OP_INSERT) begin
          i_next = cnt;
        end else if (in_op == OP_DEDUP) begin
          i_next = '0;
        end else begin
          i_next = CW'(in_position);
        end
      end
      CMD_ZERO: begin
        we     = 1'b1;
        waddr  = i[AW-1:0];
        i_next = i + CW'(1);
      end
      CMD_APPEND: begin
        we            = 1'b1;
        waddr         = cnt[AW-1:0];
        wdata         = val_r;
        cnt_next      = cnt + CW'(1);
        res_ok_next   = 1'b1;
        res_data_next = '0;
      end
      CMD_FAIL: begin
        res_ok_next   = 1'b0;
        res_data_next = (op_r == OP_READ || op_r == OP_SEARCH) ? '1 : '0;
      end
      CMD_INS: begin
        // walk down from the top, each beat moves one entry up by one
        if (pv) begin
          we    = 1'b1;
          waddr = AW'(pa + CW'(1));
          wdata = rdata;
        end
        if (i_gt_pos) begin
          re      = 1'b1;
          raddr   = AW'(i - CW'(1));
          pa_next = i - CW'(1);
          i_next  = i - CW'(1);
          pv_next = 1'b1;
        end else if (!pv) begin
          we            = 1'b1;
          waddr         = AW'(pos_r);
          wdata         = val_r;
          cnt_next      = cnt + CW'(1);
          res_ok_next   = 1'b1;
          res_data_next = '0;
        end
      end
      CMD_DEL: begin
        if (pv) begin
          we    = 1'b1;
          waddr = AW'(pa - CW'(1));
          wdata = rdata;
        end
        if (i1_lt_cnt) begin
          re      = 1'b1;
          raddr   = AW'(i + CW'(1));
          pa_next = i + CW'(1);
          i_next  = i + CW'(1);
          pv_next = 1'b1;
        end else if (!pv) begin
          cnt_next      = cnt - CW'(1);
          res_ok_next   = 1'b1;
          res_data_next = '0;
        end
      end
      CMD_RD_ISSUE: begin
        re    = 1'b1;
        raddr = AW'(pos_r);
      end
      CMD_RD_DONE: begin
        res_ok_next   = 1'b1;
        res_data_next = rdata;
      end
      CMD_SRCH: begin
        if (i_lt_cnt) begin
          re      = 1'b1;
          raddr   = i[AW-1:0];
          pa_next = i;
          i_next  = i + CW'(1);
          pv_next = 1'b1;
        end
        if (hit_val) begin
          res_ok_next   = 1'b1;
          res_data_next = 32'(pa);
        end else if (!pv && !i_lt_cnt) begin
          res_ok_next   = 1'b0;
          res_data_next = '1;
        end
      end
      CMD_CLEAR: begin
        cnt_next      = '0;
        res_ok_next   = 1'b1;
        res_data_next = '0;
      end
      CMD_DD_RDI: begin
        re     = 1'b1;
        raddr  = i[AW-1:0];
        j_next = i + CW'(1);
      end
      CMD_DD_CUR: begin
        cur_next = rdata;
      end
      CMD_DD_SCAN: begin
        if (j_lt_cnt) begin
          re      = 1'b1;
          raddr   = j[AW-1:0];
          j_next  = j + CW'(1);
          pv_next = 1'b1;
        end
        if (hit_cur) begin
          // a later copy exists, drop this one
          i_next = i + CW'(1);
        end else if (!pv && !j_lt_cnt) begin
          we        = 1'b1;
          waddr     = kept[AW-1:0];
          wdata     = cur;
          kept_next = kept + CW'(1);
          i_next    = i + CW'(1);
        end
      end
      CMD_DD_END: begin
        cnt_next      = kept;
        res_ok_next   = 1'b1;
        res_data_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      i   <= '0;
      pv  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      i   <= i_next;
      pv  <= pv_next;
    end
  end

  always_ff @(posedge clk) begin
    j        <= j_next;
    kept     <= kept_next;
    pa       <= pa_next;
    op_r     <= op_r_next;
    pos_r    <= pos_r_next;
    val_r    <= val_r_next;
    cur      <= cur_next;
    res_ok   <= res_ok_next;
    res_data <= res_data_next;
    if (cmd == CMD_PUSH) begin
      out_ok     <= res_ok;
      out_data   <= res_data;
      out_length <= LEN_W'(cnt);
    end
  end

endmodule

### rtl/core/bale_ctrl.sv
// ----------------------------------------------------------------------------
// bale_ctrl
// Sequencer of the list engine: clearing pass after reset, request
// dispatch, per-operation walks and the output handoff.
// ----------------------------------------------------------------------------
module bale_ctrl import bale_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_ZERO = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_INS  = 4'd3;
  localparam logic [3:0] S_DEL  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_SRCH = 4'd6;
  localparam logic [3:0] S_DDI  = 4'd7;
  localparam logic [3:0] S_DDC  = 4'd8;
  localparam logic [3:0] S_DDS  = 4'd9;
  localparam logic [3:0] S_PUSH = 4'd10;

  logic [3:0] state, state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = state == S_IDLE;

  always_comb begin
    state_next     = state;
    cmd            = CMD_NOP;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_ZERO: begin
        cmd = CMD_ZERO;
        if (st.zero_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_PUSH;
        case (st.op)
          OP_APPEND: cmd = st.full ? CMD_FAIL : CMD_APPEND;
          OP_INSERT: begin
            if (!st.full && st.pos_le_cnt) begin
              state_next = S_INS;
            end else begin
              cmd = CMD_FAIL;
            end
          end
          OP_DELETE: begin
            if (st.pos_lt_cnt) begin
              state_next = S_DEL;
            end else begin
              cmd = CMD_FAIL;
            end
          end
          OP_READ: begin
            if (st.pos_lt_cap) begin
              cmd        = CMD_RD_ISSUE;
              state_next = S_RD;
            end else begin
              cmd = CMD_FAIL;
            end
          end
          OP_SEARCH: begin
            if (st.pos_lt_cnt) begin
              state_next = S_SRCH;
            end else begin
              cmd = CMD_FAIL;
            end
          end
          OP_CLEAR: cmd = CMD_CLEAR;
          OP_DEDUP: state_next = S_DDI;
          default:  cmd = CMD_FAIL;
        endcase
      end
      S_INS: begin
        cmd = CMD_INS;
        if (st.ins_fin) begin
          state_next = S_PUSH;
        end
      end
      S_DEL: begin
        cmd = CMD_DEL;
        if (st.del_fin) begin
          state_next = S_PUSH;
        end
      end
      S_RD: begin
        cmd        = CMD_RD_DONE;
        state_next = S_PUSH;
      end
      S_SRCH: begin
        cmd = CMD_SRCH;
        if (st.srch_fin) begin
          state_next = S_PUSH;
        end
      end
      S_DDI: begin
        if (st.i_lt_cnt) begin
          cmd        = CMD_DD_RDI;
          state_next = S_DDC;
        end else begin
          cmd        = CMD_DD_END;
          state_next = S_PUSH;
        end
      end
      S_DDC: begin
        cmd        = CMD_DD_CUR;
        state_next = S_DDS;
      end
      S_DDS: begin
        cmd = CMD_DD_SCAN;
        if (st.dd_fin) begin
          state_next = S_DDI;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          cmd            = CMD_PUSH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ZERO;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/core/bale_checker.sv
// ----------------------------------------------------------------------------
// bale_props
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module bale_props #(
  parameter int CAPACITY = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // no request taken while the store is being zeroed
  a_zero_pass: assert property (@(posedge clk) rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("request or result during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_length: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tdata[43:33]) <= 32'(CAPACITY))
    else $error("length above capacity");

  // a failed request reports zero or all ones
  a_fail_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |->
      m_axis_tdata[32:1] == 32'h0 || m_axis_tdata[32:1] == 32'hFFFF_FFFF)
    else $error("bad data on failed request");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:44] == 4'b0)
    else $error("pad bits not zero");

endmodule

bind bounded_array_list_engine bale_props #(.CAPACITY(CAPACITY)) u_bale_props (.*);
